### hw/rtl/emulated_memory_map_decoder_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef EMULATED_MEMORY_MAP_DECODER_UNIT_MACROS_SVH
`define EMULATED_MEMORY_MAP_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EMMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EMMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/emmd_pkg.sv
`default_nettype none

package emmd_pkg;

  // Default sizes of the two stores.
  localparam int RAM_WORDS_DEF   = 1024;
  localparam int STACK_WORDS_DEF = 256;

  // Fixed points of the bus map.
  localparam logic [15:0] KEYBOARD_ADDR = 16'h9000;
  localparam logic [15:0] SCREEN_BASE   = 16'h8000;
  localparam logic [15:0] SCREEN_END    = 16'h8200;
  localparam logic [15:0] TOP_ADDR      = 16'hFFFF;

  localparam int WORD_W       = 16;
  localparam int SCREEN_OFF_W = 9;

  // Transaction kind on req_type.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Where the read word of a transaction comes from.
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_KEY,
    SRC_STACK,
    SRC_MAIN
  } src_t;

endpackage

`default_nettype wire

### hw/rtl/emmd_ram.sv
`default_nettype none

// Single-port synchronous RAM, registered read.
module emmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                        wdata,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/emulated_memory_map_decoder_unit.sv
`default_nettype none

// Word-addressed memory system of an emulated 16-bit CPU. Each transaction on
// the input channel is one read or write at a 16-bit word address; each gives
// exactly one result transaction, in order. Writes decode as screen window
// (0x8000-0x81FF, not stored, passed out on screen_*), stack (top STACK_WORDS
// addresses, entry 0xFFFF - address), keyboard register (0x9000), main RAM
// (below RAM_WORDS), else write_fault. Reads decode as keyboard, stack, main
// RAM, else 0. Main RAM and stack live in single-port synchronous RAMs; the
// keyboard word is a flop reset to zero. Reading a RAM entry never written
// returns garbage. Throughput is one transaction per clock while out_stall is low.
// The RAM's registered read and the decode stage load on the accept edge, and
// the output register loads from them once it is free. A stalled result holds
// the decode stage, and the input stalls only when both the decode stage and
// the output register are full.
module emulated_memory_map_decoder_unit #(
  parameter int RAM_WORDS   = emmd_pkg::RAM_WORDS_DEF,
  parameter int STACK_WORDS = emmd_pkg::STACK_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [15:0] address,
  input  wire logic [15:0] write_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_data,
  output logic             screen_write_valid,
  output logic [8:0]       screen_offset,
  output logic [15:0]      screen_data,
  output logic             write_fault
);

  localparam int RamAw   = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int StackAw = (STACK_WORDS > 1) ? $clog2(STACK_WORDS) : 1;

  // ---------------------------------------------------------------------
  // Address decode (combinational, on the input port)
  // ---------------------------------------------------------------------
  logic        accept;
  logic        is_write;
  logic [15:0] stack_idx;
  logic        hit_screen;
  logic        hit_stack;
  logic        hit_key;
  logic        hit_ram;

  assign accept    = in_valid && !in_stall;
  assign is_write  = (req_type == emmd_pkg::REQ_WRITE);
  // 0xFFFF - address is the bitwise complement in 16 bits
  assign stack_idx = ~address;

  assign hit_screen = (address >= emmd_pkg::SCREEN_BASE) && (address < emmd_pkg::SCREEN_END);
  assign hit_stack  = {1'b0, stack_idx} < 17'(STACK_WORDS);
  assign hit_key    = (address == emmd_pkg::KEYBOARD_ADDR);
  assign hit_ram    = {1'b0, address} < 17'(RAM_WORDS);

  // Decoded actions of the current transaction
  logic                   stack_we;
  logic                   main_we;
  logic                   key_we;
  logic                   stack_re;
  logic                   main_re;
  logic                   fault_d;
  logic                   scr_d;
  emmd_pkg::src_t         src_d;

  always_comb begin
    stack_we = 1'b0;
    main_we  = 1'b0;
    key_we   = 1'b0;
    stack_re = 1'b0;
    main_re  = 1'b0;
    fault_d  = 1'b0;
    scr_d    = 1'b0;
    src_d    = emmd_pkg::SRC_NONE;
    if (is_write) begin
      // screen > stack > keyboard > main RAM > fault
      priority if (hit_screen) begin
        scr_d = 1'b1;
      end else if (hit_stack) begin
        stack_we = 1'b1;
      end else if (hit_key) begin
        key_we = 1'b1;
      end else if (hit_ram) begin
        main_we = 1'b1;
      end else begin
        fault_d = 1'b1;
      end
    end else begin
      // keyboard > stack > main RAM > zero
      priority if (hit_key) begin
        src_d = emmd_pkg::SRC_KEY;
      end else if (hit_stack) begin
        stack_re = 1'b1;
        src_d    = emmd_pkg::SRC_STACK;
      end else if (hit_ram) begin
        main_re = 1'b1;
        src_d   = emmd_pkg::SRC_MAIN;
      end else begin
        src_d = emmd_pkg::SRC_NONE;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------
  logic [15:0] main_rdata;
  logic [15:0] stack_rdata;
  logic [15:0] key_word;

  // Read data regs only load on an accepted read, so they hold while the
  // decode stage is stalled.
  emmd_ram #(
    .WIDTH(emmd_pkg::WORD_W),
    .DEPTH(RAM_WORDS)
  ) u_main_ram (
    .clk  (clk),
    .en   (accept && (main_we || main_re)),
    .we   (main_we),
    .addr (address[RamAw-1:0]),
    .wdata(write_data),
    .rdata(main_rdata)
  );

  emmd_ram #(
    .WIDTH(emmd_pkg::WORD_W),
    .DEPTH(STACK_WORDS)
  ) u_stack_ram (
    .clk  (clk),
    .en   (accept && (stack_we || stack_re)),
    .we   (stack_we),
    .addr (stack_idx[StackAw-1:0]),
    .wdata(write_data),
    .rdata(stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word <= '0;
    end else if (accept && key_we) begin
      key_word <= write_data;
    end
  end

  // ---------------------------------------------------------------------
  // Decode stage: waits on the RAM read
  // ---------------------------------------------------------------------
  logic           p1_valid;
  emmd_pkg::src_t p1_src;
  logic [15:0]    p1_key;
  logic           p1_scr;
  logic [8:0]     p1_scr_off;
  logic [15:0]    p1_scr_data;
  logic           p1_fault;
  logic           out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = p1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (out_free) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_src      <= src_d;
      p1_key      <= key_word;
      p1_scr      <= scr_d;
      p1_scr_off  <= scr_d ? address[8:0] : 9'd0;
      p1_scr_data <= scr_d ? write_data : 16'd0;
      p1_fault    <= fault_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [15:0] rd_sel;

  always_comb begin
    unique case (p1_src)
      emmd_pkg::SRC_KEY:   rd_sel = p1_key;
      emmd_pkg::SRC_STACK: rd_sel = stack_rdata;
      emmd_pkg::SRC_MAIN:  rd_sel = main_rdata;
      default:             rd_sel = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p1_valid) begin
      read_data          <= rd_sel;
      screen_write_valid <= p1_scr;
      screen_offset      <= p1_scr_off;
      screen_data        <= p1_scr_data;
      write_fault        <= p1_fault;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/emmd_checker.sv
`default_nettype none

`include "emulated_memory_map_decoder_unit_macros.svh"

module emmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] read_data,
  input wire logic        screen_write_valid,
  input wire logic [8:0]  screen_offset,
  input wire logic [15:0] screen_data,
  input wire logic        write_fault
);

  // a screen write is mapped, so never faults
  `EMMD_ASSERT_NOW(a_scr_no_fault, out_valid && screen_write_valid, !write_fault, "screen write faulted")

  // writes return no read word
  `EMMD_ASSERT_NOW(a_wr_rd_zero, out_valid && (screen_write_valid || write_fault), read_data == 16'd0, "write returned data")

  // screen fields are quiet outside screen writes
  `EMMD_ASSERT_NOW(a_scr_quiet, out_valid && !screen_write_valid, (screen_offset == 9'd0) && (screen_data == 16'd0), "screen fields set")

  // a stalled result stays put
  `EMMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(write_fault), "stalled result changed")

endmodule

bind emulated_memory_map_decoder_unit emmd_checker u_emmd_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .read_data         (read_data),
  .screen_write_valid(screen_write_valid),
  .screen_offset     (screen_offset),
  .screen_data       (screen_data),
  .write_fault       (write_fault)
);

`default_nettype wire

### tb/tb_emulated_memory_map_decoder_unit.sv
`timescale 1ns / 1ps

module tb_emulated_memory_map_decoder_unit;

  localparam int RAM_WORDS     = emmd_pkg::RAM_WORDS_DEF;
  localparam int STACK_WORDS   = emmd_pkg::STACK_WORDS_DEF;
  localparam int N_DIRECTED    = 25;
  localparam int N_PER_PHASE   = 425;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 10;    // pause before the final check

  // Short forms of the transaction kinds for the directed table.
  localparam logic RD = emmd_pkg::REQ_READ;
  localparam logic WR = emmd_pkg::REQ_WRITE;

  // One result transaction, field order as on the ports.
  typedef struct packed {
    logic [15:0] read_data;
    logic        screen_write_valid;
    logic [8:0]  screen_offset;
    logic [15:0] screen_data;
    logic        write_fault;
  } mem_result_t;

  // Directed row; fixed rows carry a hand-typed result, others use the predictor.
  typedef struct packed {
    logic        req;
    logic [15:0] addr;
    logic [15:0] data;
    logic        fixed;
    mem_result_t result;
  } stim_row_t;

  // Idling profile of the two sides.
  typedef enum logic [1:0] {
    MODE_SLOW_SINK,    // sender idles 37%, receiver stalls 65%
    MODE_SLOW_SOURCE,  // sender idles 65%, receiver stalls 37%
    MODE_FULL_RATE     // neither side idles
  } idle_mode_t;

  localparam mem_result_t QUIET_RESULT = '{16'h0000, 1'b0, 9'h000, 16'h0000, 1'b0};
  localparam mem_result_t FAULT_RESULT = '{16'h0000, 1'b0, 9'h000, 16'h0000, 1'b1};

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        req_type   = RD;
  logic [15:0] address    = 16'h0000;
  logic [15:0] write_data = 16'h0000;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [15:0] read_data;
  logic        screen_write_valid;
  logic [8:0]  screen_offset;
  logic [15:0] screen_data;
  logic        write_fault;

  // Sideband that travels with the offered request (same NBA step as payload).
  logic        row_fixed  = 1'b0;
  mem_result_t row_result = '0;

  idle_mode_t  idle_mode  = MODE_SLOW_SINK;
  logic        hold_kick  = 1'b0;  // toggled by the sender to start a hold-off
  logic        hold_seen  = 1'b0;
  int          hold_left  = 0;
  int          quiet_cycles = 0;
  int          fail_count = 0;

  // Predictor state: store contents plus keyboard word.
  logic [15:0] main_mem  [RAM_WORDS];
  logic [15:0] stack_mem [STACK_WORDS];
  logic [15:0] key_word = 16'h0000;

  // Stimulus bookkeeping: which entries may be read back.
  bit          main_written  [RAM_WORDS];
  bit          stack_written [STACK_WORDS];
  logic [15:0] main_addrs  [$];
  logic [15:0] stack_addrs [$];

  mem_result_t pending_results [$];
  stim_row_t   dir_rows [N_DIRECTED];

  emulated_memory_map_decoder_unit dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .req_type           (req_type),
    .address            (address),
    .write_data         (write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .read_data          (read_data),
    .screen_write_valid (screen_write_valid),
    .screen_offset      (screen_offset),
    .screen_data        (screen_data),
    .write_fault        (write_fault)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stack covers the top STACK_WORDS addresses.
  function automatic bit in_stack_region(logic [15:0] addr);
    return int'(addr) > int'(emmd_pkg::TOP_ADDR) - STACK_WORDS;
  endfunction

  function automatic bit in_screen_window(logic [15:0] addr);
    return addr >= emmd_pkg::SCREEN_BASE && addr < emmd_pkg::SCREEN_END;
  endfunction

  // Decode one transaction against the predictor state, updating it on writes.
  function automatic mem_result_t decode_access(logic req, logic [15:0] addr,
                                                logic [15:0] data);
    mem_result_t r;
    logic [15:0] idx;
    r   = '0;
    idx = emmd_pkg::TOP_ADDR - addr;
    if (req == emmd_pkg::REQ_WRITE) begin
      // write priority: screen, stack, keyboard, main RAM
      if (in_screen_window(addr)) begin
        r.screen_write_valid = 1'b1;
        r.screen_offset      = 9'(addr - emmd_pkg::SCREEN_BASE);
        r.screen_data        = data;
      end else if (in_stack_region(addr)) begin
        stack_mem[idx] = data;
      end else if (addr == emmd_pkg::KEYBOARD_ADDR) begin
        key_word = data;
      end else if (int'(addr) < RAM_WORDS) begin
        main_mem[addr] = data;
      end else begin
        r.write_fault = 1'b1;
      end
    end else begin
      // read priority: keyboard, stack, main RAM; anything else reads zero
      if (addr == emmd_pkg::KEYBOARD_ADDR) begin
        r.read_data = key_word;
      end else if (in_stack_region(addr)) begin
        r.read_data = stack_mem[idx];
      end else if (int'(addr) < RAM_WORDS) begin
        r.read_data = main_mem[addr];
      end
    end
    return r;
  endfunction

  // Entries never written must never be read.
  function automatic bit safe_to_read(logic [15:0] addr);
    if (addr == emmd_pkg::KEYBOARD_ADDR) return 1'b1;
    if (in_stack_region(addr)) return stack_written[emmd_pkg::TOP_ADDR - addr];
    if (int'(addr) < RAM_WORDS) return main_written[addr];
    return 1'b1;
  endfunction

  function automatic void note_write(logic [15:0] addr);
    logic [15:0] idx;
    idx = emmd_pkg::TOP_ADDR - addr;
    if (in_screen_window(addr)) return;
    if (in_stack_region(addr)) begin
      if (!stack_written[idx]) begin
        stack_written[idx] = 1'b1;
        stack_addrs.push_back(addr);
      end
    end else if (addr != emmd_pkg::KEYBOARD_ADDR && int'(addr) < RAM_WORDS) begin
      if (!main_written[addr]) begin
        main_written[addr] = 1'b1;
        main_addrs.push_back(addr);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Random transaction, mostly well-formed accesses to written entries.
  task automatic pick_access(output logic req, output logic [15:0] addr,
                             output logic [15:0] data);
    int kind;
    kind = $urandom_range(99);
    data = 16'($urandom_range(16'hFFFF));
    if (kind < 28 || (kind < 50 && main_addrs.size() == 0)) begin
      req  = emmd_pkg::REQ_WRITE;
      addr = 16'($urandom_range(RAM_WORDS - 1));
    end else if (kind < 50) begin
      req  = emmd_pkg::REQ_READ;
      addr = main_addrs[$urandom_range(main_addrs.size() - 1)];
    end else if (kind < 60 || (kind < 70 && stack_addrs.size() == 0)) begin
      req  = emmd_pkg::REQ_WRITE;
      addr = emmd_pkg::TOP_ADDR - 16'($urandom_range(STACK_WORDS - 1));
    end else if (kind < 70) begin
      req  = emmd_pkg::REQ_READ;
      addr = stack_addrs[$urandom_range(stack_addrs.size() - 1)];
    end else if (kind < 75) begin
      req  = 1'($urandom_range(1));
      addr = emmd_pkg::KEYBOARD_ADDR;
    end else if (kind < 83) begin
      req  = 1'($urandom_range(1));
      addr = emmd_pkg::SCREEN_BASE + 16'($urandom_range(511));
    end else begin
      // noise over the whole bus, including unmapped holes
      req  = 1'($urandom_range(1));
      addr = 16'($urandom_range(16'hFFFF));
      if (req == emmd_pkg::REQ_READ && !safe_to_read(addr)) addr = emmd_pkg::KEYBOARD_ADDR;
    end
    if (req == emmd_pkg::REQ_WRITE) note_write(addr);
  endtask

  // Offer one request transaction and hold it until accepted.
  task automatic offer(logic req, logic [15:0] addr, logic [15:0] data,
                       logic fixed, mem_result_t result);
    int gap_pct;
    gap_pct = (idle_mode == MODE_SLOW_SINK)   ? 37 :
              (idle_mode == MODE_SLOW_SOURCE) ? 65 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    address    <= addr;
    write_data <= data;
    row_fixed  <= fixed;
    row_result <= result;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender pause: nothing offered until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per mode, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        MODE_SLOW_SINK:   out_stall <= ($urandom_range(99) < 65);
        MODE_SLOW_SOURCE: out_stall <= ($urandom_range(99) < 37);
        default:          out_stall <= 1'b0;
      endcase
    end
  end

  // Accepted request -> expected result, in order.
  always @(posedge clk) begin : request_track
    mem_result_t want;
    if (!rst && in_valid && !in_stall) begin
      want = decode_access(req_type, address, write_data);
      if (row_fixed) want = row_result;
      pending_results.push_back(want);
    end
  end

  // Accepted result vs. oldest expectation.
  always @(posedge clk) begin : result_check
    mem_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, read_data);
        check_field("screen_write_valid", 16'(want.screen_write_valid),
                    16'(screen_write_valid));
        check_field("screen_offset", 16'(want.screen_offset), 16'(screen_offset));
        check_field("screen_data", want.screen_data, screen_data);
        check_field("write_fault", 16'(want.write_fault), 16'(write_fault));
      end
    end
  end

  // Watchdog on cycles where neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic        req;
    logic [15:0] addr;
    logic [15:0] data;

    // Directed: reset value, range edges, screen edges, faults, unmapped reads.
    dir_rows = '{
      '{RD, emmd_pkg::KEYBOARD_ADDR, 16'hFFFF, 1'b1, QUIET_RESULT},  // keyboard resets to 0
      '{WR, 16'h0000,                16'hFFFF, 1'b1, QUIET_RESULT},
      '{WR, 16'h03FF,                16'h0000, 1'b1, QUIET_RESULT},
      '{RD, 16'h0000,                16'h0000, 1'b1, '{16'hFFFF, 1'b0, 9'h000, 16'h0, 1'b0}},
      '{RD, 16'h03FF,                16'hFFFF, 1'b1, QUIET_RESULT},
      '{WR, 16'hFFFF,                16'hA5A5, 1'b1, QUIET_RESULT},  // stack entry 0
      '{WR, 16'hFF00,                16'h5A5A, 1'b1, QUIET_RESULT},  // last stack entry
      '{RD, 16'hFFFF,                16'h0000, 1'b1, '{16'hA5A5, 1'b0, 9'h000, 16'h0, 1'b0}},
      '{RD, 16'hFF00,                16'h0000, 1'b1, '{16'h5A5A, 1'b0, 9'h000, 16'h0, 1'b0}},
      '{WR, emmd_pkg::SCREEN_BASE,   16'h1234, 1'b1, '{16'h0, 1'b1, 9'h000, 16'h1234, 1'b0}},
      '{WR, 16'h81FF,                16'hFFFF, 1'b1, '{16'h0, 1'b1, 9'h1FF, 16'hFFFF, 1'b0}},
      '{WR, emmd_pkg::SCREEN_END,    16'h0001, 1'b1, FAULT_RESULT},  // just past screen
      '{WR, 16'h0400,                16'h0002, 1'b1, FAULT_RESULT},  // just past main RAM
      '{WR, 16'hFEFF,                16'h0003, 1'b1, FAULT_RESULT},  // just below stack
      '{WR, 16'h7FFF,                16'h0004, 1'b1, FAULT_RESULT},
      '{WR, 16'h9001,                16'h0005, 1'b1, FAULT_RESULT},
      '{WR, emmd_pkg::KEYBOARD_ADDR, 16'hBEEF, 1'b1, QUIET_RESULT},
      '{RD, emmd_pkg::KEYBOARD_ADDR, 16'h0000, 1'b1, '{16'hBEEF, 1'b0, 9'h000, 16'h0, 1'b0}},
      '{RD, emmd_pkg::SCREEN_BASE,   16'hFFFF, 1'b1, QUIET_RESULT},  // screen read: 0
      '{RD, 16'h0400,                16'h0000, 1'b1, QUIET_RESULT},
      '{RD, 16'hFEFF,                16'h0000, 1'b1, QUIET_RESULT},
      '{WR, 16'h0155,                16'h6C3A, 1'b0, QUIET_RESULT},
      '{RD, 16'h0155,                16'h0000, 1'b0, QUIET_RESULT},
      '{WR, 16'hFF7F,                16'h0F0F, 1'b0, QUIET_RESULT},
      '{RD, 16'hFF7F,                16'hFFFF, 1'b0, QUIET_RESULT}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].req == emmd_pkg::REQ_WRITE) note_write(dir_rows[i].addr);
      offer(dir_rows[i].req, dir_rows[i].addr, dir_rows[i].data,
            dir_rows[i].fixed, dir_rows[i].result);
    end
    drain_results();

    // Random phases: slow sink, slow source, full rate; drain between them.
    for (int p = 0; p < 3; p++) begin
      idle_mode <= idle_mode_t'(p);
      @(posedge clk);
      for (int i = 0; i < N_PER_PHASE; i++) begin
        // long receiver hold-off while requests keep coming: fills the block
        if (p == 0 && i == 150) hold_kick <= ~hold_kick;
        pick_access(req, addr, data);
        offer(req, addr, data, 1'b0, QUIET_RESULT);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
